FILE: rtl/tie_pkg.sv
// Shared types and constants for the tiny instruction execute unit.
`timescale 1ns / 1ps

package tie_pkg;

  typedef enum logic [2:0] {
    FUNC_MOV  = 3'd0,
    FUNC_ADD  = 3'd1,
    FUNC_ADDI = 3'd2,
    FUNC_CMP  = 3'd3,
    FUNC_JE   = 3'd4,
    FUNC_JMP  = 3'd5,
    FUNC_LD   = 3'd6,
    FUNC_ST   = 3'd7
  } func_t;

  typedef enum logic [0:0] {
    CFG_HIT_COST     = 1'b0,
    CFG_MISS_PENALTY = 1'b1
  } cfg_idx_t;

  localparam int NUM_REGS_DEF  = 6;
  localparam int MEM_BYTES_DEF = 256;

  localparam logic [7:0] HIT_COST_RST     = 8'd2;
  localparam logic [7:0] MISS_PENALTY_RST = 8'd40;
  localparam logic [7:0] BASE_CYCLES      = 8'd1;
  localparam logic [7:0] CMP_CYCLES       = 8'd2;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 144;

  typedef struct packed {
    func_t      func;
    logic [2:0] r1;
    logic       we;
    logic [7:0] wdata;
    logic [7:0] cmp_val;
    logic [7:0] st_data;
    logic [7:0] base_cycles;
    logic       taken;
  } s2_t;

endpackage

FILE: rtl/tiny_isa_execute_unit.sv
// Top level of the tiny instruction execute unit: a three-register pipeline.
`timescale 1ns / 1ps

// Executes one decoded instruction per request and returns one result per request.
// The unit accepts a new instruction every cycle unless m_tready stalls the output.
// A result passes the input register, the memory read register and the result
// register in that order, and the single read port of the data memory is read in
// the middle stage. Register and memory updates of an instruction are forwarded
// to the next one, so back-to-back dependent instructions run without bubbles. The data
// memory has one valid bit per byte, cleared at reset, so it reads as zero until written.
module tiny_isa_execute_unit #(
  parameter int NUM_REGS  = tie_pkg::NUM_REGS_DEF,
  parameter int MEM_BYTES = tie_pkg::MEM_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // func[2:0], first_reg[5:3], second_reg[8:6], immediate[16:9], zero pad
  input  logic [tie_pkg::IN_TDATA_W-1:0]   s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // branch_taken[0], local_hit[1], step_cycles[9:2], cycle_total[41:10],
  // executed_total[73:42], hit_total[105:74], load_store_total[137:106], zero pad
  output logic [tie_pkg::OUT_TDATA_W-1:0]  m_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [0:0]                       cfg_index,
  input  logic [7:0]                       cfg_data
);

  localparam int AW = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;

  logic [7:0] hit_cost;
  logic [7:0] miss_penalty;

  logic [7:0] regs [NUM_REGS];
  logic       equal_flag;

  logic       s1_valid;
  tie_pkg::func_t s1_func;
  logic [2:0] s1_r1;
  logic [2:0] s1_r2;
  logic [7:0] s1_imm;

  logic         s2_valid;
  tie_pkg::s2_t s2;
  tie_pkg::s2_t s2_next;
  logic [AW-1:0] s2_addr;

  logic [7:0]  mem [MEM_BYTES];
  logic        mem_valid [MEM_BYTES];
  logic [7:0]  rdata;
  logic        rvalid;
  logic        byp;
  logic [7:0]  byp_data;

  logic [31:0] cycle_counter;
  logic [31:0] executed_counter;
  logic [31:0] hit_counter;
  logic [31:0] load_store_counter;

  logic        out_valid;
  logic        out_taken;
  logic        out_hit;
  logic [7:0]  out_step;

  logic        out_free;
  logic        s2_free;
  logic        s2_go;
  logic        s1_go;
  logic        in_go;

  logic [7:0]  op_a;
  logic [7:0]  op_b;
  logic [7:0]  raddr8;
  logic [AW-1:0] raddr;
  logic [AW-1:0] wrap_tbl [256];

  logic [7:0]  mem_byte;
  logic [7:0]  fwd_data;
  logic        s2_memop;
  logic        s2_hit;
  logic [7:0]  s2_cycles;
  logic        st_commit;

  assign out_free  = !out_valid || m_tready;
  assign s2_free   = !s2_valid || out_free;
  assign s2_go     = s2_valid && out_free;
  assign s1_go     = s1_valid && s2_free;
  assign s_tready  = !s1_valid || s2_free;
  assign in_go     = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // Byte address wrap to the memory size, worked out at elaboration.
  for (genvar g = 0; g < 256; g++) begin : g_wrap
    assign wrap_tbl[g] = AW'(g % MEM_BYTES);
  end

  // Stage two: memory byte, hit test and register write data.
  always_comb begin
    mem_byte  = byp ? byp_data : (rvalid ? rdata : 8'd0);
    s2_memop  = (s2.func == tie_pkg::FUNC_LD) || (s2.func == tie_pkg::FUNC_ST);
    s2_hit    = s2_memop && (mem_byte == s2.cmp_val);
    fwd_data  = (s2.func == tie_pkg::FUNC_LD) ? mem_byte : s2.wdata;
    s2_cycles = s2_memop ? (s2_hit ? hit_cost : miss_penalty) : s2.base_cycles;
    st_commit = s2_go && (s2.func == tie_pkg::FUNC_ST);
  end

  // Stage one: operand read with forwarding from the instruction ahead.
  always_comb begin
    op_a = 8'd0;
    op_b = 8'd0;
    for (int i = 0; i < NUM_REGS; i++) begin
      if ({29'd0, s1_r1} == 32'(i)) begin
        op_a = regs[i];
      end
      if ({29'd0, s1_r2} == 32'(i)) begin
        op_b = regs[i];
      end
    end
    if (s2_valid && s2.we && (s2.r1 == s1_r1)) begin
      op_a = fwd_data;
    end
    if (s2_valid && s2.we && (s2.r1 == s1_r2)) begin
      op_b = fwd_data;
    end

    raddr8 = (s1_func == tie_pkg::FUNC_LD) ? op_b : op_a;
    raddr  = wrap_tbl[raddr8];

    s2_next.func        = s1_func;
    s2_next.r1          = s1_r1;
    s2_next.cmp_val     = (s1_func == tie_pkg::FUNC_ST) ? op_b : op_a;
    s2_next.st_data     = op_b;
    s2_next.base_cycles = (s1_func == tie_pkg::FUNC_CMP) ? tie_pkg::CMP_CYCLES
                                                          : tie_pkg::BASE_CYCLES;
    s2_next.taken       = (s1_func == tie_pkg::FUNC_JMP) ||
                          ((s1_func == tie_pkg::FUNC_JE) && equal_flag);
    s2_next.we          = 1'b0;
    s2_next.wdata       = 8'd0;
    case (s1_func)
      tie_pkg::FUNC_MOV: begin
        s2_next.we    = 1'b1;
        s2_next.wdata = s1_imm;
      end
      tie_pkg::FUNC_ADD: begin
        s2_next.we    = 1'b1;
        s2_next.wdata = op_a + op_b;
      end
      tie_pkg::FUNC_ADDI: begin
        s2_next.we    = 1'b1;
        s2_next.wdata = op_a + s1_imm;
      end
      tie_pkg::FUNC_LD: begin
        s2_next.we = 1'b1;
      end
      default: begin
        s2_next.we = 1'b0;
      end
    endcase
    if ({29'd0, s1_r1} >= 32'(NUM_REGS)) begin
      s2_next.we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_cost     <= tie_pkg::HIT_COST_RST;
      miss_penalty <= tie_pkg::MISS_PENALTY_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tie_pkg::CFG_HIT_COST:     hit_cost     <= cfg_data;
        tie_pkg::CFG_MISS_PENALTY: miss_penalty <= cfg_data;
        default:                   hit_cost     <= hit_cost;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      if (in_go) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
    end
    if (in_go) begin
      s1_func <= tie_pkg::func_t'(s_tdata[2:0]);
      s1_r1   <= s_tdata[5:3];
      s1_r2   <= s_tdata[8:6];
      s1_imm  <= s_tdata[16:9];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid   <= 1'b0;
      equal_flag <= 1'b0;
    end else begin
      if (s1_go) begin
        s2_valid <= 1'b1;
        if (s1_func == tie_pkg::FUNC_CMP) begin
          equal_flag <= (op_a == op_b);
        end
      end else if (s2_go) begin
        s2_valid <= 1'b0;
      end
    end
    if (s1_go) begin
      s2      <= s2_next;
      s2_addr <= raddr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs[i] <= 8'd0;
      end
    end else begin
      for (int i = 0; i < NUM_REGS; i++) begin
        if (s2_go && s2.we && ({29'd0, s2.r1} == 32'(i))) begin
          regs[i] <= fwd_data;
        end
      end
    end
  end

  // Data memory with a registered read port and a bypass for a store at the same edge.
  always_ff @(posedge clk) begin
    if (st_commit) begin
      mem[s2_addr] <= s2.st_data;
    end
    if (s1_go) begin
      rdata    <= mem[raddr];
      rvalid   <= mem_valid[raddr];
      byp      <= st_commit && (s2_addr == raddr);
      byp_data <= s2.st_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MEM_BYTES; i++) begin
        mem_valid[i] <= 1'b0;
      end
    end else if (st_commit) begin
      mem_valid[s2_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid          <= 1'b0;
      cycle_counter      <= 32'd0;
      executed_counter   <= 32'd0;
      hit_counter        <= 32'd0;
      load_store_counter <= 32'd0;
    end else begin
      if (s2_go) begin
        out_valid          <= 1'b1;
        cycle_counter      <= cycle_counter + {24'd0, s2_cycles};
        executed_counter   <= executed_counter + 32'd1;
        hit_counter        <= hit_counter + {31'd0, s2_hit};
        load_store_counter <= load_store_counter + {31'd0, s2_memop};
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
    if (s2_go) begin
      out_taken <= s2.taken;
      out_hit   <= s2_hit;
      out_step  <= s2_cycles;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, load_store_counter, hit_counter, executed_counter,
                     cycle_counter, out_step, out_hit, out_taken};

  a_store_marks_valid: assert property (@(posedge clk) disable iff (rst)
    st_commit |=> mem_valid[$past(s2_addr)])
    else $error("stored byte not marked valid");

  a_exec_count: assert property (@(posedge clk) disable iff (rst)
    s2_go |=> executed_counter == $past(executed_counter) + 32'd1)
    else $error("executed count did not advance on commit");

  a_hit_only_memop: assert property (@(posedge clk) disable iff (rst)
    (s2_go && !s2_memop) |=> !out_hit && (hit_counter == $past(hit_counter)))
    else $error("hit reported for a non-memory instruction");

endmodule

FILE: tb/tb_tiny_isa_execute_unit.sv
// Self-checking testbench for the tiny instruction execute unit.
`timescale 1ns / 1ps

module tb_tiny_isa_execute_unit;
  import tie_pkg::*;

  localparam int N_REGS = NUM_REGS_DEF;
  localparam int N_BYTES = MEM_BYTES_DEF;
  localparam int DRAIN_CYCLES = 6;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [7:0] imm;
    logic [2:0] src;
    logic [2:0] dst;
    func_t      func;
  } instr_t;

  typedef struct packed {
    logic [31:0] load_store_total;
    logic [31:0] hit_total;
    logic [31:0] executed_total;
    logic [31:0] cycle_total;
    logic [7:0]  step_cycles;
    logic        local_hit;
    logic        branch_taken;
  } result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [0:0]             cfg_index = '0;
  logic [7:0]             cfg_data = '0;

  instr_t  instr_q[$];
  result_t result_q[$];

  logic [7:0]  gpr[N_REGS];
  logic [7:0]  dmem[N_BYTES];
  logic        eq_flag;
  logic [31:0] cyc_count, exec_count, hit_count, ldst_count;
  logic [7:0]  hit_cycles = HIT_COST_RST;
  logic [7:0]  miss_cycles = MISS_PENALTY_RST;

  bit in_fired, cfg_fired, idle_en, hold_used;
  int errors, accepted, results_seen, phase_no, hold_at;
  int burst_left, gap_left, hold_left, mode_left, stall_mode, tick;

  tiny_isa_execute_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic logic [7:0] gpr_rd(logic [2:0] idx);
    return (idx < N_REGS) ? gpr[idx] : 8'd0;
  endfunction

  task automatic gpr_wr(logic [2:0] idx, logic [7:0] val);
    if (idx < N_REGS) gpr[idx] = val;
  endtask

  task automatic execute_instr(instr_t ins);
    result_t    r;
    logic [7:0] a, b;
    int         addr;
    logic       hit, memop;
    r = '0;
    r.step_cycles = BASE_CYCLES;
    a = gpr_rd(ins.dst);
    b = gpr_rd(ins.src);
    hit = 1'b0;
    memop = 1'b0;
    case (ins.func)
      FUNC_MOV: gpr_wr(ins.dst, ins.imm);
      FUNC_ADD: gpr_wr(ins.dst, a + b);
      FUNC_ADDI: gpr_wr(ins.dst, a + ins.imm);
      FUNC_CMP: begin
        eq_flag = (a == b);
        r.step_cycles = CMP_CYCLES;
      end
      FUNC_JE: r.branch_taken = eq_flag;
      FUNC_JMP: r.branch_taken = 1'b1;
      FUNC_LD: begin
        addr = int'(b) % N_BYTES;
        memop = 1'b1;
        hit = (dmem[addr] == a);
        if (!hit) gpr_wr(ins.dst, dmem[addr]);
      end
      FUNC_ST: begin
        addr = int'(a) % N_BYTES;
        memop = 1'b1;
        hit = (dmem[addr] == b);
        dmem[addr] = b;
      end
    endcase
    if (memop) begin
      r.step_cycles = hit ? hit_cycles : miss_cycles;
      r.local_hit = hit;
      ldst_count = ldst_count + 1;
      if (hit) hit_count = hit_count + 1;
    end
    exec_count = exec_count + 1;
    cyc_count = cyc_count + r.step_cycles;
    r.cycle_total = cyc_count;
    r.executed_total = exec_count;
    r.hit_total = hit_count;
    r.load_store_total = ldst_count;
    result_q.push_back(r);
  endtask

  task automatic report_mismatch(string what);
    $display("mismatch at result %0d: %s", results_seen, what);
    errors++;
  endtask

  task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  always @(posedge clk) begin
    in_fired = 1'b0;
    cfg_fired = 1'b0;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        cfg_fired = 1'b1;
        if (cfg_index == CFG_HIT_COST) hit_cycles = cfg_data;
        else miss_cycles = cfg_data;
      end
      if (m_tvalid && m_tready) begin
        result_t got, want;
        got = result_t'(m_tdata[$bits(result_t)-1:0]);
        if (result_q.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = result_q.pop_front();
          compare_field("branch_taken", got.branch_taken, want.branch_taken);
          compare_field("local_hit", got.local_hit, want.local_hit);
          compare_field("step_cycles", got.step_cycles, want.step_cycles);
          compare_field("cycle_total", got.cycle_total, want.cycle_total);
          compare_field("executed_total", got.executed_total, want.executed_total);
          compare_field("hit_total", got.hit_total, want.hit_total);
          compare_field("load_store_total", got.load_store_total, want.load_store_total);
        end
        results_seen++;
      end
      if (s_tvalid && s_tready) begin
        in_fired = 1'b1;
        accepted++;
        execute_instr(instr_t'(s_tdata[$bits(instr_t)-1:0]));
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_fired) begin
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (instr_q.size() > 0) begin
        s_tdata <= IN_TDATA_W'(instr_q.pop_front());
        s_tvalid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 30);
          gap_left = (!idle_en || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (!hold_used && phase_no == 3 && accepted >= hold_at) begin
        hold_used = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(20, 120);
        stall_mode = idle_en ? $urandom_range(0, 3) : 0;
      end
      mode_left--;
      tick++;
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (stall_mode)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(0, 9) > 2);
          2: m_tready <= (tick % 3 == 0);
          default: m_tready <= tick[0];
        endcase
      end
    end
  end

  function automatic instr_t mk(func_t f, logic [2:0] dst, logic [2:0] src, logic [7:0] imm);
    instr_t ins;
    ins.func = f;
    ins.dst = dst;
    ins.src = src;
    ins.imm = imm;
    return ins;
  endfunction

  function automatic logic [2:0] rand_reg();
    return ($urandom_range(0, 99) < 3) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
  endfunction

  function automatic logic [7:0] rand_imm();
    return $urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(0, 4) - 2);
  endfunction

  function automatic func_t rand_func();
    int w;
    w = $urandom_range(0, 99);
    if (w < 12) return FUNC_MOV;
    if (w < 22) return FUNC_ADD;
    if (w < 32) return FUNC_ADDI;
    if (w < 44) return FUNC_CMP;
    if (w < 52) return FUNC_JE;
    if (w < 58) return FUNC_JMP;
    if (w < 79) return FUNC_LD;
    return FUNC_ST;
  endfunction

  task automatic add_random(int n);
    int         k;
    logic [2:0] a, b;
    k = 0;
    while (k < n) begin
      a = rand_reg();
      b = rand_reg();
      case ($urandom_range(0, 9))
        0, 1: begin
          instr_q.push_back(mk(FUNC_ST, a, b, rand_imm()));
          instr_q.push_back(mk(FUNC_LD, $urandom_range(0, 1) ? b : rand_reg(), a, rand_imm()));
          k += 2;
        end
        2: begin
          instr_q.push_back(mk(FUNC_CMP, a, b, rand_imm()));
          instr_q.push_back(mk(FUNC_JE, rand_reg(), rand_reg(), rand_imm()));
          k += 2;
        end
        default: begin
          instr_q.push_back(mk(rand_func(), a, b, rand_imm()));
          k++;
        end
      endcase
    end
  endtask

  task automatic add_directed();
    instr_q.push_back(mk(FUNC_MOV, 0, 0, 127));
    instr_q.push_back(mk(FUNC_MOV, 1, 0, -128));
    instr_q.push_back(mk(FUNC_ADD, 0, 1, 0));
    instr_q.push_back(mk(FUNC_ADDI, 0, 0, 1));
    instr_q.push_back(mk(FUNC_CMP, 0, 2, 0));
    instr_q.push_back(mk(FUNC_JE, 0, 0, 0));
    instr_q.push_back(mk(FUNC_JMP, 0, 0, 0));
    instr_q.push_back(mk(FUNC_CMP, 0, 1, 0));
    instr_q.push_back(mk(FUNC_JE, 0, 0, 0));
    instr_q.push_back(mk(FUNC_ST, 1, 0, 0));
    instr_q.push_back(mk(FUNC_ST, 1, 1, 0));
    instr_q.push_back(mk(FUNC_LD, 2, 1, 0));
    instr_q.push_back(mk(FUNC_LD, 2, 1, 0));
    instr_q.push_back(mk(FUNC_MOV, 5, 0, -1));
    instr_q.push_back(mk(FUNC_ST, 5, 5, 0));
    instr_q.push_back(mk(FUNC_LD, 3, 5, 0));
    instr_q.push_back(mk(FUNC_MOV, 6, 0, 5));
    instr_q.push_back(mk(FUNC_ADD, 0, 7, 0));
    instr_q.push_back(mk(FUNC_CMP, 6, 7, 0));
    instr_q.push_back(mk(FUNC_JE, 0, 0, 0));
    instr_q.push_back(mk(FUNC_ST, 7, 6, 0));
    instr_q.push_back(mk(FUNC_LD, 7, 6, 0));
    instr_q.push_back(mk(FUNC_ADDI, 4, 0, -128));
    instr_q.push_back(mk(FUNC_ADDI, 4, 0, 127));
    instr_q.push_back(mk(FUNC_ADD, 4, 5, 0));
  endtask

  task automatic wait_idle();
    while (instr_q.size() != 0 || s_tvalid || result_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_cfg(cfg_idx_t idx, logic [7:0] val);
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(negedge clk); while (!cfg_fired);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    for (int i = 0; i < N_REGS; i++) gpr[i] = '0;
    for (int i = 0; i < N_BYTES; i++) dmem[i] = '0;
    eq_flag = 1'b0;
    cyc_count = '0;
    exec_count = '0;
    hit_count = '0;
    ldst_count = '0;
    idle_en = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    phase_no = 1;
    add_directed();

    write_cfg(CFG_HIT_COST, 8'd1);
    write_cfg(CFG_MISS_PENALTY, 8'd255);
    phase_no = 2;
    add_random(400);

    write_cfg(CFG_HIT_COST, 8'd255);
    write_cfg(CFG_MISS_PENALTY, 8'd1);
    hold_at = accepted + 50;
    phase_no = 3;
    add_random(400);

    write_cfg(CFG_HIT_COST, 8'd0);
    write_cfg(CFG_MISS_PENALTY, 8'($urandom_range(1, 255)));
    phase_no = 4;
    add_random(150);

    write_cfg(CFG_HIT_COST, 8'($urandom_range(1, 255)));
    write_cfg(CFG_MISS_PENALTY, 8'($urandom_range(1, 255)));
    idle_en = 1'b0;
    phase_no = 5;
    add_random(500);

    write_cfg(CFG_HIT_COST, HIT_COST_RST);
    write_cfg(CFG_MISS_PENALTY, MISS_PENALTY_RST);
    idle_en = 1'b1;
    phase_no = 6;
    add_random(400);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #(10_000_000);
    $display("status: fail");
    $finish;
  end

endmodule

FILE: tiny_isa_execute_unit.f
rtl/tie_pkg.sv
rtl/tiny_isa_execute_unit.sv
tb/tb_tiny_isa_execute_unit.sv
